// ===== rtl/core/lfu_pkg.sv =====
// Shared types and constants for the LFU cache table.
package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int COUNT_BITS  = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [VAL_W-1:0]      VAL_NONE = {VAL_W{1'b1}};

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [IDX_W-1:0]      rank_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [VAL_W-1:0]      val_t;

    // One entry as seen at the scan read port.
    typedef struct packed {
        logic  valid;
        key_t  key;
        val_t  value;
        cnt_t  count;
        rank_t rank;
    } entry_t;

    // Accumulated outcome of one scan over the table.
    typedef struct packed {
        logic  found;
        idx_t  found_idx;
        rank_t found_rank;
        cnt_t  found_cnt;
        val_t  found_value;
        logic  vic_vld;
        idx_t  vic_idx;
        cnt_t  vic_cnt;
        rank_t vic_rank;
        key_t  vic_key;
        logic  free_vld;
        idx_t  free_idx;
    } scan_res_t;

endpackage

// ===== rtl/core/lfu_scan_unit.sv =====
// Per-entry compare unit: key match, LFU/LRU victim and first free slot over a scan.
module lfu_scan_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               step,
    input  lfu_pkg::idx_t      idx,
    input  lfu_pkg::entry_t    cur,
    input  lfu_pkg::key_t      key,
    output lfu_pkg::scan_res_t res
);
    import lfu_pkg::*;

    scan_res_t acc_reg;
    scan_res_t acc_next;
    logic      match;
    logic      better;

    assign match  = cur.valid && (cur.key == key);
    // lower count wins, equal count goes to the older entry
    assign better = cur.valid && (!acc_reg.vic_vld || (cur.count < acc_reg.vic_cnt) ||
                    ((cur.count == acc_reg.vic_cnt) && (cur.rank > acc_reg.vic_rank)));

    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (step)
        begin
            if (match && !acc_reg.found)
            begin
                acc_next.found       = 1'b1;
                acc_next.found_idx   = idx;
                acc_next.found_rank  = cur.rank;
                acc_next.found_cnt   = cur.count;
                acc_next.found_value = cur.value;
            end
            if (better)
            begin
                acc_next.vic_vld  = 1'b1;
                acc_next.vic_idx  = idx;
                acc_next.vic_cnt  = cur.count;
                acc_next.vic_rank = cur.rank;
                acc_next.vic_key  = cur.key;
            end
            if (!cur.valid && !acc_reg.free_vld)
            begin
                acc_next.free_vld = 1'b1;
                acc_next.free_idx = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign res = acc_reg;

endmodule

// ===== rtl/core/lfu_cache_table_unit.sv =====
// LFU cache table with LRU tie-break: one lookup or insert per item, in steps: take the
// beat, walk every table entry (16) through the single compare unit that searches for
// the key, the eviction victim and the first free slot, then write back the entry, shift
// the recency ranks and load the result register. s_tready is low from the accepted beat
// until the write-back cycle; a held result stalls the write-back.
// Capacity is written on the cfg channel; the user is to write it only while the block
// is idle, which the block itself does not enforce.
module lfu_cache_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,    // capacity_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [31:0] lookup_key, [63:32] new_value
    input  logic [0:0]  s_tuser,     // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]  m_tuser      // [0] hit, [1] evicted
);
    import lfu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]       state_reg, state_next;
    idx_t             idx_reg, idx_next;
    logic [CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             op_reg;
    key_t             key_reg;
    val_t             val_reg;

    logic             valid_reg [MAX_ENTRIES];
    logic             valid_next [MAX_ENTRIES];
    rank_t            rank_reg [MAX_ENTRIES];
    rank_t            rank_next [MAX_ENTRIES];
    key_t             key_mem [MAX_ENTRIES];
    val_t             val_mem [MAX_ENTRIES];
    cnt_t             cnt_mem [MAX_ENTRIES];

    logic             out_valid_reg;
    logic [63:0]      out_data_reg;
    logic [1:0]       out_user_reg;

    logic             accept;
    logic             do_update;
    entry_t           cur;
    scan_res_t        res;
    logic [OCC_W-1:0] eff_cap;
    logic             miss_put;
    logic             evict;
    logic             insert;
    idx_t             slot;
    cnt_t             cnt_inc;
    val_t             rd_value;
    key_t             ev_key;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign do_update = (state_reg == ST_UPDATE) && (!out_valid_reg || m_tready);

    assign cur.valid = valid_reg[idx_reg];
    assign cur.key   = key_mem[idx_reg];
    assign cur.value = val_mem[idx_reg];
    assign cur.count = cnt_mem[idx_reg];
    assign cur.rank  = rank_reg[idx_reg];

    lfu_scan_unit u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .step  (state_reg == ST_SCAN),
        .idx   (idx_reg),
        .cur   (cur),
        .key   (key_reg),
        .res   (res)
    );

    always_comb
    begin
        priority if (cap_reg == '0)
            eff_cap = OCC_W'(1);
        else if (OCC_W'(cap_reg) > OCC_W'(MAX_ENTRIES))
            eff_cap = OCC_W'(MAX_ENTRIES);
        else
            eff_cap = OCC_W'(cap_reg);
    end

    assign miss_put = !res.found && (op_reg == OP_PUT);
    assign evict    = miss_put && (occ_reg >= eff_cap) && res.vic_vld;
    // lowest free slot after the eviction
    assign slot     = (evict && (!res.free_vld || (res.vic_idx < res.free_idx))) ?
                      res.vic_idx : res.free_idx;
    assign insert   = miss_put && (evict || res.free_vld);
    assign cnt_inc  = (res.found_cnt == CNT_MAX) ? res.found_cnt : res.found_cnt + CNT_ONE;
    assign rd_value = (res.found && (op_reg == OP_GET)) ? res.found_value : VAL_NONE;
    assign ev_key   = evict ? res.vic_key : '0;

    always_comb
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            valid_next[j] = valid_reg[j];
            rank_next[j]  = rank_reg[j];
            if (res.found)
            begin
                if (idx_t'(j) == res.found_idx)
                    rank_next[j] = '0;
                else if (valid_reg[j] && (rank_reg[j] < res.found_rank))
                    rank_next[j] = rank_reg[j] + rank_t'(1);
            end
            else if (insert)
            begin
                if (evict && (idx_t'(j) == res.vic_idx))
                    valid_next[j] = 1'b0;
                if (idx_t'(j) == slot)
                begin
                    valid_next[j] = 1'b1;
                    rank_next[j]  = '0;
                end
                else if (valid_reg[j] && !(evict && (idx_t'(j) == res.vic_idx)))
                begin
                    // close the victim's gap, then age by one for the newcomer
                    if (evict && (rank_reg[j] > res.vic_rank))
                        rank_next[j] = rank_reg[j];
                    else
                        rank_next[j] = rank_reg[j] + rank_t'(1);
                end
            end
        end
    end

    assign occ_next = (insert && !evict) ? occ_reg + OCC_W'(1) : occ_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + idx_t'(1);
                if (idx_reg == idx_t'(MAX_ENTRIES - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (do_update)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cap_reg       <= CAP_W'(MAX_ENTRIES);
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < MAX_ENTRIES; j++)
                valid_reg[j] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (do_update)
            begin
                occ_reg <= occ_next;
                for (int j = 0; j < MAX_ENTRIES; j++)
                    valid_reg[j] <= valid_next[j];
            end
            if (do_update)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser[0];
            key_reg <= s_tdata[31:0];
            val_reg <= s_tdata[63:32];
        end
        if (do_update)
        begin
            for (int j = 0; j < MAX_ENTRIES; j++)
                rank_reg[j] <= rank_next[j];
            out_data_reg <= {ev_key, rd_value};
            out_user_reg <= {evict, res.found};
            if (res.found)
            begin
                cnt_mem[res.found_idx] <= cnt_inc;
                if (op_reg == OP_PUT)
                    val_mem[res.found_idx] <= val_reg;
            end
            else if (insert)
            begin
                key_mem[slot] <= key_reg;
                val_mem[slot] <= val_reg;
                cnt_mem[slot] <= CNT_ONE;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/core/lfu_checker.sv =====
// Port-level checks for the LFU cache table, bound to the top level.
module lfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one item at a time: no second beat right after an accepted one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting a beat");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("eviction reported on a hit");

    a_evict_read_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("eviction beat carries a read value");

    a_no_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[63:32] == 32'd0))
        else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_table_unit lfu_checker u_lfu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the LFU cache table unit, with its own cache predictor.
`timescale 1ns / 1ps

module tb;
    import lfu_pkg::*;

    localparam int TIMEOUT_CYCLES = 6_000_000;
    localparam int PRINT_LIMIT    = 30;

    typedef struct packed {
        logic hit;
        val_t read_value;
        logic evicted;
        key_t evicted_key;
    } reply_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    lfu_cache_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Predicted cache contents
    logic       tbl_valid [MAX_ENTRIES];
    key_t       tbl_key   [MAX_ENTRIES];
    val_t       tbl_value [MAX_ENTRIES];
    cnt_t       tbl_cnt   [MAX_ENTRIES];
    int         tbl_rank  [MAX_ENTRIES];
    int         tbl_occupancy;
    logic [4:0] capacity_reg;

    reply_t pending_replies [$];
    int     error_count;
    int     burst_left;
    bit     steady_traffic;  // no sender gaps, receiver always ready
    int     rx_left;
    int     rx_mode;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // One lookup or insert against the predicted table; returns the reply it produces.
    function automatic reply_t apply_access(logic op, key_t k, val_t v);
        reply_t r;
        int     found;
        int     victim;
        int     slot;
        int     eff_cap;
        int     r0;
        r.hit         = 1'b0;
        r.read_value  = VAL_NONE;
        r.evicted     = 1'b0;
        r.evicted_key = '0;
        found  = -1;
        victim = -1;
        slot   = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (found < 0 && tbl_valid[i] && tbl_key[i] == k)
                found = i;
        if (found >= 0) begin
            r.hit = 1'b1;
            if (op == OP_GET)
                r.read_value = tbl_value[found];
            else
                tbl_value[found] = v;
            r0 = tbl_rank[found];
            for (int j = 0; j < MAX_ENTRIES; j++)
                if (tbl_valid[j] && j != found && tbl_rank[j] < r0)
                    tbl_rank[j]++;
            tbl_rank[found] = 0;
            if (tbl_cnt[found] != CNT_MAX)
                tbl_cnt[found]++;
        end
        else if (op == OP_PUT) begin
            eff_cap = (capacity_reg == 0) ? 1 :
                      (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
            if (tbl_occupancy >= eff_cap) begin
                // lowest count wins, ties go to the least recent
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (!tbl_valid[i])
                        continue;
                    if (victim < 0 || tbl_cnt[i] < tbl_cnt[victim] ||
                        (tbl_cnt[i] == tbl_cnt[victim] && tbl_rank[i] > tbl_rank[victim]))
                        victim = i;
                end
                if (victim >= 0) begin
                    r.evicted         = 1'b1;
                    r.evicted_key     = tbl_key[victim];
                    r0                = tbl_rank[victim];
                    tbl_valid[victim] = 1'b0;
                    for (int j = 0; j < MAX_ENTRIES; j++)
                        if (tbl_valid[j] && tbl_rank[j] > r0)
                            tbl_rank[j]--;
                    if (tbl_occupancy > 0)
                        tbl_occupancy--;
                end
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
            if (slot >= 0) begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (tbl_valid[i])
                        tbl_rank[i]++;
                tbl_valid[slot] = 1'b1;
                tbl_key[slot]   = k;
                tbl_value[slot] = v;
                tbl_cnt[slot]   = CNT_ONE;
                tbl_rank[slot]  = 0;
                tbl_occupancy++;
            end
        end
        return r;
    endfunction

    // Send one access beat; valid stays up afterwards unless a gap follows.
    task automatic issue_access(logic op, key_t k, val_t v);
        int gap;
        if (!steady_traffic) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, k};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        pending_replies.push_back(apply_access(op, k, v));
    endtask

    task automatic wait_for_drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_replies.size() != 0);
    endtask

    task automatic write_capacity(logic [4:0] cap);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        capacity_reg = cap;
        cfg_valid <= 1'b0;
    endtask

    // Result side stall pattern: segments of free flow, random, sparse, and ready then stalled
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(4, 60);
        end
        rx_left--;
        if (steady_traffic)
            m_tready <= 1'b1;
        else
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_left > 30);
            endcase
    end

    always @(posedge clk) begin : result_check
        reply_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("result beat with nothing outstanding", m_tdata[31:0], '0);
            end
            else begin
                want = pending_replies.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", 32'(m_tuser[0]), 32'(want.hit));
                if (m_tdata[31:0] !== want.read_value)
                    report_mismatch("read_value", m_tdata[31:0], want.read_value);
                if (m_tuser[1] !== want.evicted)
                    report_mismatch("evicted", 32'(m_tuser[1]), 32'(want.evicted));
                if (m_tdata[63:32] !== want.evicted_key)
                    report_mismatch("evicted_key", m_tdata[63:32], want.evicted_key);
            end
        end
    end

    // A frequently used key must outlive a fresh key when the table is full.
    task automatic test_frequency_retention();
        key_t hot;
        key_t cold;
        key_t late;
        hot  = 32'h0BAD_F00D;
        cold = 32'h1357_9BDF;
        late = 32'h2468_ACE0;
        steady_traffic = 1'b1;
        write_capacity(5'd2);
        issue_access(OP_PUT, hot, 32'h0000_0042);
        for (int n = 0; n < 40; n++)
            issue_access(OP_GET, hot, $urandom);
        issue_access(OP_PUT, cold, 32'h0000_0001);
        issue_access(OP_PUT, late, 32'h0000_0002);
        issue_access(OP_GET, hot, '0);
        issue_access(OP_GET, cold, '0);
        wait_for_drain();
        steady_traffic = 1'b0;
    endtask

    task automatic test_get_put_basics();
        write_capacity(5'd16);
        issue_access(OP_GET, 32'h0000_0000, 32'h1111_1111);
        issue_access(OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
        issue_access(OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        issue_access(OP_GET, 32'h0000_0000, '0);
        issue_access(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_access(OP_GET, 32'h0000_0000, '0);
        issue_access(OP_GET, 32'h1234_5678, '0);
    endtask

    // Capacity below occupancy, zero capacity and out-of-range capacity
    task automatic test_capacity_limits();
        write_capacity(5'd3);
        issue_access(OP_PUT, 32'hA5A5_A5A5, 32'h0000_0003);
        issue_access(OP_PUT, 32'h5A5A_5A5A, 32'h0000_0004);
        issue_access(OP_GET, 32'hA5A5_A5A5, '0);
        write_capacity(5'd0);
        issue_access(OP_PUT, 32'h1111_1111, 32'h0000_0005);
        issue_access(OP_PUT, 32'h2222_2222, 32'h0000_0006);
        issue_access(OP_GET, 32'h1111_1111, '0);
        write_capacity(5'd31);
        issue_access(OP_PUT, 32'h3333_3333, 32'h0000_0007);
        issue_access(OP_PUT, 32'h4444_4444, 32'h0000_0008);
        issue_access(OP_PUT, 32'h5555_5555, 32'h0000_0009);
    endtask

    task automatic test_random_traffic();
        logic [4:0] cap_plan [10];
        key_t       key_pool [$];
        int         eff_cap;
        int         pool_sz;
        logic       op;
        key_t       k;
        cap_plan = '{5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31, 5'd0, 5'd5, 5'd17, 5'd3};
        cap_plan[9] = 5'($urandom_range(0, 31));
        for (int phase = 0; phase < 10; phase++) begin
            write_capacity(cap_plan[phase]);
            eff_cap = (cap_plan[phase] == 0) ? 1 :
                      (cap_plan[phase] > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_plan[phase]);
            pool_sz = eff_cap + $urandom_range(1, 6);
            key_pool.delete();
            for (int n = 0; n < pool_sz; n++)
                case ($urandom_range(0, 9))
                    0:       key_pool.push_back(32'h0000_0000);
                    1:       key_pool.push_back(32'hFFFF_FFFF);
                    default: key_pool.push_back($urandom);
                endcase
            for (int n = 0; n < 115; n++) begin
                if (phase == 4 && n == 60)
                    wait_for_drain();
                op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
                k  = ($urandom_range(0, 7) == 0) ? key_t'($urandom)
                                                 : key_pool[$urandom_range(0, pool_sz - 1)];
                issue_access(op, k, $urandom);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_cnt[i]   = '0;
            tbl_rank[i]  = 0;
        end
        tbl_occupancy  = 0;
        capacity_reg   = 5'd16;
        error_count    = 0;
        burst_left     = 0;
        steady_traffic = 1'b0;
        rx_left        = 0;
        rx_mode        = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frequency_retention();
        test_get_put_basics();
        test_capacity_limits();
        test_random_traffic();

        wait_for_drain();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("PASS lfu_cache_table_unit");
        else
            $display("FAIL lfu_cache_table_unit");
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("ERROR: timeout with %0d results outstanding", pending_replies.size());
        $display("FAIL lfu_cache_table_unit");
        $finish;
    end

endmodule
